// ===== sv/mcma_adaptive_equalizer_top_macros.svh =====
// Assertion macros for the adaptive equalizer checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef MCMA_ADAPTIVE_EQUALIZER_TOP_MACROS_SVH
`define MCMA_ADAPTIVE_EQUALIZER_TOP_MACROS_SVH

// consequent in the cycle after the antecedent
`define MCMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// consequent in the same cycle as the antecedent
`define MCMA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/mcma_pkg.sv =====
// Shared types, codes and arithmetic helpers for the MCMA equalizer.
// No dependencies.
package mcma_pkg;

  localparam int NTAP_DEF   = 15;
  localparam int S_DATA_W   = 88;
  localparam int S_USER_W   = 2;
  localparam int M_DATA_W   = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int A_W        = 40;
  localparam int B_W        = 24;
  localparam int P_W        = 64;
  localparam int ACC_W      = 48;

  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_TAP     = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] CFG_STEP   = 2'd0;
  localparam logic [1:0] CFG_RADIUS = 2'd1;
  localparam logic [1:0] CFG_MODE   = 2'd2;
  localparam logic [1:0] CFG_IVL    = 2'd3;

  localparam logic [15:0] STEP_RST   = 16'd1024;
  localparam logic [15:0] RADIUS_RST = 16'd4096;
  localparam logic [2:0]  MODE_RST   = 3'd1;
  localparam logic [3:0]  IVL_RST    = 4'd1;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_CMA  = 3'd1;
  localparam logic [2:0] ERR_MMA2 = 3'd2;
  localparam logic [2:0] ERR_MMA3 = 3'd3;
  localparam logic [2:0] ERR_MMA4 = 3'd4;
  localparam logic [2:0] ERR_MMA5 = 3'd5;
  localparam logic [2:0] ERR_NCMA = 3'd6;
  localparam logic [2:0] ERR_TWO  = 3'd7;

  // Q.26 constants
  localparam logic signed [39:0] ONE_Q26 = 40'sd67108864;
  localparam logic signed [39:0] C_4_7   = 40'sd38347922;
  localparam logic signed [39:0] C_2_7   = 40'sd19173961;
  localparam logic signed [39:0] C_1_7   = 40'sd9586981;
  localparam logic signed [39:0] C_9_49  = 40'sd12326118;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_FILT = 11'b00000000010,
    S_RND  = 11'b00000000100,
    S_SQ   = 11'b00000001000,
    S_ERR  = 11'b00000010000,
    S_EMIT = 11'b00000100000,
    S_KMUL = 11'b00001000000,
    S_KRND = 11'b00010000000,
    S_SMUL = 11'b00100000000,
    S_SRND = 11'b01000000000,
    S_UPD  = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic [A_W-1:0] a_re;
    logic [A_W-1:0] a_im;
    logic [B_W-1:0] b_re;
    logic [B_W-1:0] b_im;
  } cmul_in_t;

  typedef struct packed {
    logic [P_W-1:0] rr;
    logic [P_W-1:0] ii;
    logic [P_W-1:0] ir;
    logic [P_W-1:0] ri;
  } cmul_out_t;

  function automatic logic signed [39:0] abs40(input logic signed [39:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [63:0] rnd64(input logic signed [63:0] v,
                                               input int unsigned s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    else if (v < -48'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
    if (v > 40'sd8388607) return 24'sh7fffff;
    else if (v < -40'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

  // Mode error of one output component a (Q2.13), a2 = a*a; result Q.26.
  function automatic logic signed [39:0] err_of(input logic [2:0] mode,
                                                input logic signed [15:0] a,
                                                input logic signed [39:0] a2,
                                                input logic [15:0] r0);
    logic signed [39:0] e1;
    logic signed [39:0] e2;
    logic signed [39:0] e3;
    logic signed [39:0] res;
    e1 = '0;
    e2 = '0;
    e3 = '0;
    unique case (mode)
      ERR_NONE: res = '0;
      ERR_CMA:  res = $signed({10'b0, r0, 14'b0}) - a2;
      ERR_MMA2: res = 40'sd10 * ONE_Q26 - 40'sd18 * a2;
      ERR_MMA3: res = 40'sd4 * ONE_Q26 - abs40(40'sd9 * a2 - 40'sd5 * ONE_Q26);
      ERR_MMA4: res = 40'sd20 * ONE_Q26 - abs40(40'sd49 * a2 - 40'sd29 * ONE_Q26);
      ERR_MMA5: res = 40'sd16 * ONE_Q26 - abs40(40'sd49 * a2 - 40'sd20 * ONE_Q26);
      ERR_NCMA: begin
        e1 = (abs40(40'(a)) <<< 13) - C_4_7;
        e2 = abs40(e1) - C_2_7;
        e3 = abs40(e2) - C_1_7;
        // sign of the ring product picks the polarity
        res = ((e1 < 0) ^ (e2 < 0) ^ (a < 0)) ? e3 : -e3;
      end
      ERR_TWO: begin
        e1 = C_9_49 - a2;
        e2 = ONE_Q26 - a2;
        res = (abs40(e1) < abs40(e2)) ? e1 : e2;
      end
    endcase
    return res;
  endfunction

endpackage

// ===== sv/mcma_ram.sv =====
// Generic single write port RAM with registered read.
// Depends on mcma_pkg for default sizes.
module mcma_ram #(
  parameter int WIDTH = mcma_pkg::A_W,
  parameter int DEPTH = mcma_pkg::NTAP_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/mcma_cmul.sv =====
// Shared four-product complex multiplier, registered output.
// Depends on mcma_pkg (operand and product structs).
module mcma_cmul (
  input  logic                 clk,
  input  mcma_pkg::cmul_in_t   op,
  output mcma_pkg::cmul_out_t  prod
);
  import mcma_pkg::*;

  always_ff @(posedge clk) begin
    prod.rr <= $signed(op.a_re) * $signed(op.b_re);
    prod.ii <= $signed(op.a_im) * $signed(op.b_im);
    prod.ir <= $signed(op.a_im) * $signed(op.b_re);
    prod.ri <= $signed(op.a_re) * $signed(op.b_im);
  end
endmodule

// ===== sv/mcma_adaptive_equalizer_top.sv =====
// A sample word that fills the line runs the filter pass, rounding, squaring and error
// steps; its result waits in S_EMIT until the output takes it. s_tready stays low until
// the word is done, and one shared complex multiplier does the filter and update passes.
// Tap write, restart and ignored words leave the block idle and ready.
// Reset (rst, synchronous): registers to defaults, taps read zero, fill and phase clear.
// Uses mcma_pkg, mcma_ram, mcma_cmul.
module mcma_adaptive_equalizer_top #(
  parameter int NTAP = mcma_pkg::NTAP_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // sample_re, sample_im, tap_index, coef_re, coef_im, zero pad
  input  logic [mcma_pkg::S_DATA_W-1:0]    s_tdata,
  // opcode
  input  logic [mcma_pkg::S_USER_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_re, out_im, error_metric
  output logic [mcma_pkg::M_DATA_W-1:0]    m_tdata,
  input  logic                             cfg_we,
  input  logic [mcma_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcma_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mcma_pkg::*;

  localparam int AW = $clog2(NTAP);
  localparam int CW = $clog2(NTAP + 1);
  localparam logic [AW-1:0] LAST_A = AW'(NTAP - 1);
  localparam logic [CW-1:0] NTAP_C = CW'(NTAP);
  localparam logic [6:0]    NTAP_7 = 7'(NTAP);

  state_t state;

  logic [15:0] step, radius;
  logic [2:0]  mode;
  logic [3:0]  ivl;

  logic [CW-1:0] fill, fill_next, cnt;
  logic [2:0]    phase;
  logic [AW-1:0] wp, wp_next, rd_ptr, addr1, addr2;
  logic          rd_v, mul_v, issue, do_upd;
  logic [NTAP-1:0] tap_valid;

  logic signed [ACC_W-1:0] acc_re, acc_im, fsum_re, fsum_im;
  logic signed [15:0] yr, yi, metric;
  logic signed [39:0] er, ei, kr, ki, a2r, a2i, m40, dr, di;
  logic signed [23:0] t1_re, t1_im, tq_re, tq_im, new_re, new_im;

  logic [1:0]  op;
  logic        accept;
  logic [31:0] dly_rdata;
  logic [47:0] tap_rdata, tap_wdata;
  logic        tap_we, dly_we;
  logic [AW-1:0] tap_waddr;
  logic signed [15:0] dq_re, dq_im;
  logic [3:0]  iv, ph1;

  cmul_in_t  mop;
  cmul_out_t prod;

  assign op       = s_tuser;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign dq_re    = dly_rdata[15:0];
  assign dq_im    = dly_rdata[31:16];
  assign tq_re    = tap_valid[addr1] ? tap_rdata[23:0]  : '0;
  assign tq_im    = tap_valid[addr1] ? tap_rdata[47:24] : '0;
  assign issue    = ((state == S_FILT) || (state == S_UPD)) && (cnt < NTAP_C);
  assign wp_next  = (wp == LAST_A) ? '0 : wp + 1'b1;
  assign fill_next = (fill < NTAP_C) ? fill + 1'b1 : fill;

  assign dly_we = accept && (op == OP_SAMPLE);

  always_comb begin
    if (state == S_UPD) begin
      tap_we    = mul_v;
      tap_waddr = addr2;
      tap_wdata = {new_im, new_re};
    end else begin
      tap_we    = accept && (op == OP_TAP) && ({1'b0, s_tdata[37:32]} < NTAP_7);
      tap_waddr = s_tdata[32 +: AW];
      tap_wdata = {s_tdata[85:62], s_tdata[61:38]};
    end
  end

  mcma_ram #(.WIDTH(32), .DEPTH(NTAP)) u_dly (
    .clk(clk), .we(dly_we), .waddr(wp), .wdata(s_tdata[31:0]),
    .raddr(rd_ptr), .rdata(dly_rdata)
  );

  mcma_ram #(.WIDTH(48), .DEPTH(NTAP)) u_tap (
    .clk(clk), .we(tap_we), .waddr(tap_waddr), .wdata(tap_wdata),
    .raddr(cnt[AW-1:0]), .rdata(tap_rdata)
  );

  // operand select for the shared multiplier
  always_comb begin
    priority case (1'b1)
      (state == S_SQ): begin
        mop.a_re = 40'(yr);  mop.a_im = 40'(yi);
        mop.b_re = 24'(yr);  mop.b_im = 24'(yi);
      end
      (state == S_KMUL): begin
        mop.a_re = er;       mop.a_im = ei;
        mop.b_re = 24'(yr);  mop.b_im = 24'(yi);
      end
      (state == S_SMUL): begin
        mop.a_re = kr;       mop.a_im = ki;
        mop.b_re = {8'b0, step};
        mop.b_im = {8'b0, step};
      end
      (state == S_UPD): begin
        mop.a_re = kr;       mop.a_im = ki;
        mop.b_re = 24'(dq_re); mop.b_im = 24'(dq_im);
      end
      default: begin
        mop.a_re = 40'(dq_re); mop.a_im = 40'(dq_im);
        mop.b_re = tq_re;      mop.b_im = tq_im;
      end
    endcase
  end

  mcma_cmul u_mul (.clk(clk), .op(mop), .prod(prod));

  always_comb begin
    fsum_re = $signed(prod.rr[ACC_W-1:0]) - $signed(prod.ii[ACC_W-1:0]);
    fsum_im = $signed(prod.ir[ACC_W-1:0]) + $signed(prod.ri[ACC_W-1:0]);
    a2r = $signed(prod.rr[39:0]);
    a2i = $signed(prod.ii[39:0]);
    if (mode == ERR_MMA2) m40 = a2r + a2i - $signed({9'b0, radius, 15'b0});
    else m40 = err_of(mode, yr, a2r, radius);
    dr = 40'(rnd64($signed(prod.rr) + $signed(prod.ii), 18));
    di = 40'(rnd64($signed(prod.ir) - $signed(prod.ri), 18));
    new_re = sat24(40'(t1_re) + dr);
    new_im = sat24(40'(t1_im) + di);
    iv = (ivl == 4'd0) ? 4'd1 : ((ivl > 4'd8) ? 4'd8 : ivl);
    ph1 = {1'b0, phase} + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= STEP_RST;
      radius <= RADIUS_RST;
      mode   <= MODE_RST;
      ivl    <= IVL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP:   step   <= cfg_data;
        CFG_RADIUS: radius <= cfg_data;
        CFG_MODE:   mode   <= cfg_data[2:0];
        CFG_IVL:    ivl    <= cfg_data[3:0];
      endcase
    end
  end

  // pass pipeline: read issue -> RAM data -> product
  always_ff @(posedge clk) begin
    if (issue) addr1 <= cnt[AW-1:0];
    if (rd_v) begin
      addr2 <= addr1;
      t1_re <= tq_re;
      t1_im <= tq_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      phase     <= '0;
      wp        <= '0;
      rd_ptr    <= '0;
      cnt       <= '0;
      rd_v      <= 1'b0;
      mul_v     <= 1'b0;
      do_upd    <= 1'b0;
      tap_valid <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (tap_we) tap_valid[tap_waddr] <= 1'b1;
      rd_v  <= issue;
      mul_v <= rd_v;
      if (issue) begin
        cnt    <= cnt + 1'b1;
        rd_ptr <= (rd_ptr == LAST_A) ? '0 : rd_ptr + 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == OP_SAMPLE) begin
              wp     <= wp_next;
              rd_ptr <= wp_next;
              cnt    <= '0;
              fill   <= fill_next;
              acc_re <= '0;
              acc_im <= '0;
              if (fill_next == NTAP_C) state <= S_FILT;
            end else if (op == OP_RESTART) begin
              fill  <= '0;
              phase <= '0;
            end
          end
        end
        S_FILT: begin
          if (mul_v) begin
            acc_re <= acc_re + fsum_re;
            acc_im <= acc_im + fsum_im;
          end
          if (cnt == NTAP_C && !rd_v && !mul_v) state <= S_RND;
        end
        S_RND: begin
          yr    <= sat16((acc_re + 48'sd1048576) >>> 21);
          yi    <= sat16((acc_im + 48'sd1048576) >>> 21);
          state <= S_SQ;
        end
        S_SQ: state <= S_ERR;
        S_ERR: begin
          er     <= err_of(mode, yr, a2r, radius);
          ei     <= err_of(mode, yi, a2i, radius);
          metric <= sat16(48'((m40 + 40'sd16384) >>> 15));
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {metric, yi, yr};
            do_upd   <= (phase == 3'd0);
            phase    <= (ph1 >= iv) ? 3'd0 : ph1[2:0];
            state    <= (phase == 3'd0) ? S_KMUL : S_IDLE;
          end
        end
        S_KMUL: state <= S_KRND;
        S_KRND: begin
          kr    <= 40'(rnd64($signed(prod.rr), 13));
          ki    <= 40'(rnd64($signed(prod.ii), 13));
          state <= S_SMUL;
        end
        S_SMUL: state <= S_SRND;
        S_SRND: begin
          kr     <= 40'(rnd64($signed(prod.rr), 20));
          ki     <= 40'(rnd64($signed(prod.ii), 20));
          rd_ptr <= wp;
          cnt    <= '0;
          state  <= do_upd ? S_UPD : S_IDLE;
        end
        S_UPD: begin
          if (cnt == NTAP_C && !rd_v && !mul_v) state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== sv/mcma_chk.sv =====
// Port-level checker for the MCMA equalizer, bound to the top level.
// Depends on mcma_pkg and the macro header.
`include "mcma_adaptive_equalizer_top_macros.svh"

module mcma_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [mcma_pkg::S_USER_W-1:0] s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mcma_pkg::M_DATA_W-1:0] m_tdata
);
  import mcma_pkg::*;

  `MCMA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped")
  `MCMA_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result word changed")
  `MCMA_ASSERT_NEXT(a_ctl_one_cycle, s_tvalid && s_tready && (s_tuser != OP_SAMPLE), s_tready, "control word stalled input")
  `MCMA_ASSERT_SAME(a_out_from_busy, $rose(m_tvalid), $past(!s_tready), "result while idle")

endmodule

bind mcma_adaptive_equalizer_top mcma_chk u_chk (.*);
